/* src/lmhp_pkg.sv */
package lmhp_pkg;

  // Characters that the line assembler and the number parser look for.
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_LEAD_E  = 8'h45;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_LOW_A   = 8'h61;
  localparam logic [7:0] CH_LOW_F   = 8'h66;
  localparam logic [7:0] CH_UP_A    = 8'h41;
  localparam logic [7:0] CH_UP_F    = 8'h46;
  localparam logic [7:0] CH_LOW_X   = 8'h78;
  localparam logic [7:0] CH_UP_X    = 8'h58;
  localparam logic [7:0] CH_NUL     = 8'h00;

  // Largest magnitude kept by the accumulator (two to the 31st).
  localparam logic [35:0] MAG_LIMIT = 36'h0_8000_0000;
  localparam logic [31:0] POS_MAX   = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_MIN   = 32'h8000_0000;

  // Phases of the base-16 number parser.
  typedef enum logic [2:0] {
    PH_SPACE  = 3'd0,
    PH_SIGN   = 3'd1,
    PH_ZERO   = 3'd2,
    PH_DIGITS = 3'd3,
    PH_DONE   = 3'd4
  } phase_t;

  // Kinds of message reported at the end of a line.
  typedef enum logic [1:0] {
    MSG_POSITION  = 2'd0,
    MSG_MALFORMED = 2'd1,
    MSG_UNKNOWN   = 2'd2
  } msg_kind_t;

  // Running state of the number parser.
  typedef struct packed {
    phase_t      phase;
    logic        neg;
    logic [31:0] mag;
    logic        ovf;
  } num_state_t;

  // What the line assembler reports for the byte now being taken.
  typedef struct packed {
    logic               last;
    msg_kind_t          kind;
    logic signed [31:0] position;
  } line_res_t;

endpackage

/* src/line_message_hex_position_parser.sv */
// Takes one received byte per transaction and reports one message per line.
// A line ends at a newline or when it reaches LINE_CAPACITY-1 bytes. Lines
// that start with "E:" give msg_kind 0 with the text after the colon read as
// a base-16 number (leading whitespace, optional sign, optional 0x prefix,
// saturated to 32-bit signed); "E" without a colon gives kind 1, anything
// else kind 2 with position zero. Throughput is one byte per clock unless
// stalled: the byte register feeds a combinational classify and shift-and-add
// step, and the message is registered when the closing byte is stepped. Bytes
// keep flowing while a message waits in the output register; only a second
// line end stalls the input until that message is taken.
module line_message_hex_position_parser #(
  parameter int LINE_CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_msg_kind,
  output logic signed [31:0] out_position
);

  logic                in_valid_r;
  logic [7:0]          in_byte_r;
  logic                out_valid_r;
  logic [1:0]          out_kind_r;
  logic signed [31:0]  out_pos_r;
  logic                stall;
  logic                step;
  lmhp_pkg::line_res_t res;

  lmhp_line_asm #(
    .LINE_CAPACITY (LINE_CAPACITY)
  ) u_line (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .rx_byte (in_byte_r),
    .res     (res)
  );

  // A held byte waits only if it closes a line while a message is pending.
  assign stall    = in_valid_r && res.last && out_valid_r && !out_ready;
  assign step     = in_valid_r && !stall;
  assign in_ready = !in_valid_r || !stall;

  // Input byte register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      in_byte_r <= in_rx_byte;
    end
  end

  // Output message register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step && res.last) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (step && res.last) begin
      out_kind_r <= res.kind;
      out_pos_r  <= res.position;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_msg_kind = out_kind_r;
  assign out_position = out_pos_r;

  // Only position messages carry a nonzero position.
  a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_msg_kind != lmhp_pkg::MSG_POSITION) |-> (out_position == 32'sd0))
    else $error("nonzero position on a non-position message");

  // A message is never written over one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res.last) |-> (!out_valid_r || out_ready))
    else $error("pending message overwritten");

  // The input stalls only behind a pending, untaken message.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !in_ready) |-> (out_valid_r && !out_ready))
    else $error("input stalled without a blocked output");

  // A line end always shows up as a valid message in the next cycle.
  a_line_end_out: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res.last) |=> out_valid)
    else $error("line end did not produce a message");

endmodule

/* src/lmhp_num_parser.sv */
module lmhp_num_parser (
  input  logic [7:0]          rx_byte,
  input  lmhp_pkg::num_state_t cur,
  output lmhp_pkg::num_state_t nxt
);

  logic        is_digit;
  logic [3:0]  digit;
  logic        is_space;
  logic [35:0] shifted;
  lmhp_pkg::num_state_t acc;

  // Hex digit decode, either case.
  always_comb begin
    is_digit = 1'b1;
    digit    = 4'd0;
    if (rx_byte >= lmhp_pkg::CH_ZERO && rx_byte <= lmhp_pkg::CH_NINE) begin
      digit = 4'(rx_byte - lmhp_pkg::CH_ZERO);
    end else if (rx_byte >= lmhp_pkg::CH_LOW_A && rx_byte <= lmhp_pkg::CH_LOW_F) begin
      digit = 4'(rx_byte - lmhp_pkg::CH_LOW_A + 8'd10);
    end else if (rx_byte >= lmhp_pkg::CH_UP_A && rx_byte <= lmhp_pkg::CH_UP_F) begin
      digit = 4'(rx_byte - lmhp_pkg::CH_UP_A + 8'd10);
    end else begin
      is_digit = 1'b0;
    end
  end

  assign is_space = (rx_byte == lmhp_pkg::CH_SPACE) ||
                    (rx_byte >= lmhp_pkg::CH_TAB && rx_byte <= lmhp_pkg::CH_CR);

  // Shift-and-add of one digit; the magnitude saturates just past 2^31.
  assign shifted = {cur.mag, 4'b0000} + {32'd0, digit};

  always_comb begin
    acc = cur;
    if (!cur.ovf) begin
      if (shifted > lmhp_pkg::MAG_LIMIT) begin
        acc.ovf = 1'b1;
      end else begin
        acc.mag = shifted[31:0];
      end
    end
  end

  // Phase sequencing: whitespace, sign, zero of a 0x prefix, digits, done.
  always_comb begin
    nxt = cur;
    if (cur.phase != lmhp_pkg::PH_DONE) begin
      if (rx_byte == lmhp_pkg::CH_NUL) begin
        nxt.phase = lmhp_pkg::PH_DONE;
      end else begin
        case (cur.phase)
          lmhp_pkg::PH_SPACE, lmhp_pkg::PH_SIGN: begin
            if (cur.phase == lmhp_pkg::PH_SPACE && is_space) begin
              nxt = cur;
            end else if (cur.phase == lmhp_pkg::PH_SPACE &&
                         (rx_byte == lmhp_pkg::CH_PLUS || rx_byte == lmhp_pkg::CH_MINUS)) begin
              nxt.neg   = (rx_byte == lmhp_pkg::CH_MINUS);
              nxt.phase = lmhp_pkg::PH_SIGN;
            end else if (rx_byte == lmhp_pkg::CH_ZERO) begin
              nxt.phase = lmhp_pkg::PH_ZERO;
            end else if (is_digit) begin
              nxt       = acc;
              nxt.phase = lmhp_pkg::PH_DIGITS;
            end else begin
              nxt.phase = lmhp_pkg::PH_DONE;
            end
          end
          lmhp_pkg::PH_ZERO: begin
            if (rx_byte == lmhp_pkg::CH_LOW_X || rx_byte == lmhp_pkg::CH_UP_X) begin
              nxt.phase = lmhp_pkg::PH_DIGITS;
            end else if (is_digit) begin
              nxt       = acc;
              nxt.phase = lmhp_pkg::PH_DIGITS;
            end else begin
              nxt.phase = lmhp_pkg::PH_DONE;
            end
          end
          default: begin
            if (is_digit) begin
              nxt = acc;
            end else begin
              nxt.phase = lmhp_pkg::PH_DONE;
            end
          end
        endcase
      end
    end
  end

endmodule

/* src/lmhp_line_asm.sv */
module lmhp_line_asm #(
  parameter int LINE_CAPACITY = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          rx_byte,
  output lmhp_pkg::line_res_t res
);

  localparam int LenW = $clog2(LINE_CAPACITY);
  localparam logic [LenW-1:0] LastIdx = LenW'(LINE_CAPACITY - 2);

  logic [LenW-1:0]      len_r, len_nxt;
  logic [7:0]           lead_r, lead_nxt;
  logic                 colon_r, colon_nxt;
  lmhp_pkg::num_state_t num_r, num_nxt, num_parsed;
  logic [31:0]          final_pos;

  lmhp_num_parser u_num (
    .rx_byte (rx_byte),
    .cur     (num_r),
    .nxt     (num_parsed)
  );

  // Per-byte line bookkeeping: first byte, colon check, then number bytes.
  always_comb begin
    lead_nxt  = lead_r;
    colon_nxt = colon_r;
    num_nxt   = num_r;
    if (len_r == '0) begin
      lead_nxt = rx_byte;
    end else if (len_r == LenW'(1)) begin
      colon_nxt = (rx_byte == lmhp_pkg::CH_COLON);
    end else if (lead_r == lmhp_pkg::CH_LEAD_E && colon_r) begin
      num_nxt = num_parsed;
    end
  end

  // Clamp the magnitude to the signed 32-bit range.
  always_comb begin
    if (num_nxt.neg) begin
      final_pos = num_nxt.ovf ? lmhp_pkg::NEG_MIN : (32'd0 - num_nxt.mag);
    end else if (num_nxt.ovf || num_nxt.mag > lmhp_pkg::POS_MAX) begin
      final_pos = lmhp_pkg::POS_MAX;
    end else begin
      final_pos = num_nxt.mag;
    end
  end

  // Result for the byte now presented; it counts only when step is high.
  always_comb begin
    res.last     = (rx_byte == lmhp_pkg::CH_NEWLINE) || (len_r == LastIdx);
    res.kind     = lmhp_pkg::MSG_UNKNOWN;
    res.position = '0;
    if (lead_nxt == lmhp_pkg::CH_LEAD_E) begin
      if (colon_nxt) begin
        res.kind     = lmhp_pkg::MSG_POSITION;
        res.position = final_pos;
      end else begin
        res.kind = lmhp_pkg::MSG_MALFORMED;
      end
    end
  end

  // Line state registers, cleared at every line end.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r         <= '0;
      lead_r        <= '0;
      colon_r       <= 1'b0;
      num_r.phase   <= lmhp_pkg::PH_SPACE;
      num_r.neg     <= 1'b0;
      num_r.mag     <= '0;
      num_r.ovf     <= 1'b0;
    end else if (step) begin
      if (res.last) begin
        len_r       <= '0;
        lead_r      <= '0;
        colon_r     <= 1'b0;
        num_r.phase <= lmhp_pkg::PH_SPACE;
        num_r.neg   <= 1'b0;
        num_r.mag   <= '0;
        num_r.ovf   <= 1'b0;
      end else begin
        len_r   <= len_r + LenW'(1);
        lead_r  <= lead_nxt;
        colon_r <= colon_nxt;
        num_r   <= num_nxt;
      end
    end
  end

endmodule
